@@ rtl/polygon_rect_overlap_test_unit_defines.svh @@
// Assertion macros for the polygon/rectangle overlap test unit.
`ifndef POLYGON_RECT_OVERLAP_TEST_UNIT_DEFINES_SVH
`define POLYGON_RECT_OVERLAP_TEST_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PROT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: check failed");
`define PROT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");
`else
`define PROT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PROT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/prot_pkg.sv @@
// Shared types and constants of the polygon/rectangle overlap test unit.
package prot_pkg;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;
	localparam int CLIP_RIGHT_RST  = 4096;
	localparam int CLIP_BOTTOM_RST = 4096;
	localparam logic [1:0] TALLY_MAX = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VTX,
		ST_EDGE_LD,
		ST_LAUNCH,
		ST_ORIENT,
		ST_SIDE,
		ST_CROSS,
		ST_CROSS_CMP,
		ST_NEXT,
		ST_RESULT
	} state_t;

	// product-difference request to the shared comparator
	typedef struct packed {
		logic start;
	} pd_ctl_t;
endpackage

@@ rtl/prot_if.sv @@
// Valid/ready channel interface carrying a generic payload.
interface prot_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/prot_pdiff.sv @@
// Iterative sign of a*b - c*d; one shift-add step per cycle.
module prot_pdiff #(
	parameter int OW = 18
) (
	input  logic clk,
	input  logic arst_n,
	input  prot_pkg::pd_ctl_t ctl,
	input  logic signed [OW-1:0] a,
	input  logic signed [OW-1:0] b,
	input  logic signed [OW-1:0] c,
	input  logic signed [OW-1:0] d,
	output logic done,
	output logic [1:0] sgn
);
	localparam int PW = 2*OW + 2;
	localparam int CW = $clog2(OW+1);
	logic [OW-1:0] mb_q, md_q;
	logic signed [PW-1:0] ea_q, ec_q, acc_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic signed [PW-1:0] acc_nx;

	always_comb begin
		acc_nx = acc_q;
		if (mb_q[0]) acc_nx = acc_nx + ea_q;
		if (md_q[0]) acc_nx = acc_nx - ec_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(OW-1)) busy_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// operands: negate a and c with b/d so multipliers are nonnegative
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			mb_q  <= b[OW-1] ? OW'(-b) : OW'(b);
			md_q  <= d[OW-1] ? OW'(-d) : OW'(d);
			ea_q  <= b[OW-1] ? -PW'(a) : PW'(a);
			ec_q  <= d[OW-1] ? -PW'(c) : PW'(c);
		end else if (busy_q) begin
			acc_q <= acc_nx;
			mb_q  <= mb_q >> 1;
			md_q  <= md_q >> 1;
			ea_q  <= ea_q <<< 1;
			ec_q  <= ec_q <<< 1;
		end
	end

	assign done = busy_q && (cnt_q == CW'(OW-1));
	assign sgn  = (acc_nx == '0) ? 2'b00 : (acc_nx[PW-1] ? 2'b11 : 2'b01);
endmodule

@@ rtl/polygon_rect_overlap_test_unit.sv @@
// Flow: a first vertex holds ready low only in the cycle after its transaction. A later vertex
// tests one edge: 16 orientation jobs (4 per rectangle side), each a launch state followed by
// shift-add steps in the product-difference unit, then at most one crossing job, before ready
// returns. A last vertex of a polygon with three or more vertices adds the closing edge, then
// holds its result until taken; one vertex in flight.
// Reset (arst_n low, asynchronous): clip registers to 0,0,4096,4096, polygon state cleared.
`include "polygon_rect_overlap_test_unit_defines.svh"
module polygon_rect_overlap_test_unit #(
	parameter int COORD_WIDTH = prot_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [prot_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data,
	prot_if.sink   vertex,
	prot_if.source result
);
	localparam int CW = COORD_WIDTH;
	// operand width: differences, sums and k+1 all fit in CW+2 bits
	localparam int OW = CW + 2;
	typedef logic signed [OW-1:0] op_t;

	// configuration registers
	logic signed [CW-1:0] cl_q, ct_q, cr_q, cb_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cl_q <= '0;
			ct_q <= '0;
			cr_q <= CW'(prot_pkg::CLIP_RIGHT_RST);
			cb_q <= CW'(prot_pkg::CLIP_BOTTOM_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				prot_pkg::REG_CLIP_LEFT:   cl_q <= cfg_data;
				prot_pkg::REG_CLIP_TOP:    ct_q <= cfg_data;
				prot_pkg::REG_CLIP_RIGHT:  cr_q <= cfg_data;
				prot_pkg::REG_CLIP_BOTTOM: cb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// center, truncated toward zero
	op_t sx, sy, px, py;
	assign sx = OW'(cl_q) + OW'(cr_q);
	assign sy = OW'(ct_q) + OW'(cb_q);
	assign px = (sx + op_t'(sx[OW-1] & sx[0])) >>> 1;
	assign py = (sy + op_t'(sy[OW-1] & sy[0])) >>> 1;

	prot_pkg::state_t st_q, st_d;

	// polygon state
	logic signed [CW-1:0] fx_q, fy_q, qx_q, qy_q;   // first, prior vertex
	logic [1:0] tally_q;
	logic hit_q, par_q;
	// current item
	logic signed [CW-1:0] vx_q, vy_q;
	logic last_q;
	// edge under test: a -> b
	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;
	logic closing_q;          // working on closing edge
	logic [1:0] side_q;       // rectangle side index
	logic [1:0] oi_q;         // orientation index 0..3
	logic [1:0] o_q [4];      // orientation signs
	logic cross_alt_q;        // crossing test uses k (not k+1)
	logic res_ov_q, res_few_q;

	// rectangle side endpoints c -> d
	logic signed [CW-1:0] cxs, cys, dxs, dys;
	always_comb begin
		unique case (side_q)
			2'd0: begin cxs = cl_q; cys = ct_q; dxs = cr_q; dys = ct_q; end
			2'd1: begin cxs = cr_q; cys = ct_q; dxs = cr_q; dys = cb_q; end
			2'd2: begin cxs = cr_q; cys = cb_q; dxs = cl_q; dys = cb_q; end
			default: begin cxs = cl_q; cys = cb_q; dxs = cl_q; dys = ct_q; end
		endcase
	end

	// orient(p,q,r) = sign((q-p)x*(r-p)y - (q-p)y*(r-p)x)
	logic signed [CW-1:0] p_x, p_y, q_x, q_y, r_x, r_y;
	always_comb begin
		unique case (oi_q)
			2'd0: begin p_x=ax_q; p_y=ay_q; q_x=bx_q; q_y=by_q; r_x=cxs; r_y=cys; end
			2'd1: begin p_x=ax_q; p_y=ay_q; q_x=bx_q; q_y=by_q; r_x=dxs; r_y=dys; end
			2'd2: begin p_x=cxs; p_y=cys; q_x=dxs; q_y=dys; r_x=ax_q; r_y=ay_q; end
			default: begin p_x=cxs; p_y=cys; q_x=dxs; q_y=dys; r_x=bx_q; r_y=by_q; end
		endcase
	end

	// crossing operands for edge vj=a -> vi=b
	op_t den_r, numa_r, numb, kk, den, numa;
	logic a_above, b_above;
	assign a_above = op_t'(ay_q) > py;
	assign b_above = op_t'(by_q) > py;
	assign den_r  = op_t'(by_q) - op_t'(ay_q);
	assign numa_r = py - op_t'(ay_q);
	assign numb   = op_t'(bx_q) - op_t'(ax_q);
	assign den    = den_r[OW-1] ? -den_r : den_r;
	assign numa   = den_r[OW-1] ? -numa_r : numa_r;
	assign kk     = px - op_t'(ax_q);
	logic same_sgn;   // sgn(numa)*sgn(numb) >= 0
	assign same_sgn = (numa == '0) || (numb == '0) || (numa[OW-1] == numb[OW-1]);

	// shared product-difference unit; operands are captured on the start cycle
	prot_pkg::pd_ctl_t pd_ctl;
	op_t pa, pb, pc, pd;
	logic pd_done;
	logic [1:0] pd_sgn;
	always_comb begin
		if (st_q == prot_pkg::ST_CROSS || st_q == prot_pkg::ST_CROSS_CMP) begin
			pa = same_sgn ? kk + op_t'(1) : kk;
			pb = den;
			pc = numa;
			pd = numb;
		end else begin
			pa = op_t'(q_x) - op_t'(p_x);
			pb = op_t'(r_y) - op_t'(p_y);
			pc = op_t'(q_y) - op_t'(p_y);
			pd = op_t'(r_x) - op_t'(p_x);
		end
	end

	prot_pdiff #(.OW(OW)) u_pdiff (
		.clk(clk), .arst_n(arst_n), .ctl(pd_ctl),
		.a(pa), .b(pb), .c(pc), .d(pd), .done(pd_done), .sgn(pd_sgn)
	);

	// point-in-rectangle tests for edge ends
	function automatic logic in_rect(input logic signed [CW-1:0] x, y,
			input logic signed [CW-1:0] l, t, r, b);
		in_rect = (x >= l) && (x <= r) && (y >= t) && (y <= b);
	endfunction

	// collinear bounding-box overlap
	logic signed [CW-1:0] amnx, amxx, amny, amxy, cmnx, cmxx, cmny, cmxy;
	assign amnx = (ax_q < bx_q) ? ax_q : bx_q;
	assign amxx = (ax_q < bx_q) ? bx_q : ax_q;
	assign amny = (ay_q < by_q) ? ay_q : by_q;
	assign amxy = (ay_q < by_q) ? by_q : ay_q;
	assign cmnx = (cxs < dxs) ? cxs : dxs;
	assign cmxx = (cxs < dxs) ? dxs : cxs;
	assign cmny = (cys < dys) ? cys : dys;
	assign cmxy = (cys < dys) ? dys : cys;
	logic box_ov, seg_meet;
	assign box_ov = amnx <= cmxx && amxx >= cmnx && amny <= cmxy && amxy >= cmny;
	always_comb begin
		if ((o_q[0] != 2'b00 && o_q[0] == o_q[1]) || (o_q[2] != 2'b00 && o_q[2] == o_q[3]))
			seg_meet = 1'b0;
		else if (o_q[0] == 2'b00 && o_q[1] == 2'b00)
			seg_meet = box_ov;
		else
			seg_meet = 1'b1;
	end

	logic take;
	assign take = vertex.valid && vertex.ready;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			prot_pkg::ST_IDLE: if (take) st_d = prot_pkg::ST_VTX;
			prot_pkg::ST_VTX: begin
				if (tally_q == 2'd0) st_d = last_q ? prot_pkg::ST_RESULT : prot_pkg::ST_IDLE;
				else st_d = prot_pkg::ST_EDGE_LD;
			end
			prot_pkg::ST_EDGE_LD: st_d = prot_pkg::ST_LAUNCH;
			prot_pkg::ST_LAUNCH: st_d = prot_pkg::ST_ORIENT;
			prot_pkg::ST_ORIENT: if (pd_done) st_d = (oi_q == 2'd3) ? prot_pkg::ST_SIDE
				: prot_pkg::ST_LAUNCH;
			prot_pkg::ST_SIDE: st_d = (side_q == 2'd3) ? prot_pkg::ST_CROSS
				: prot_pkg::ST_LAUNCH;
			prot_pkg::ST_CROSS: st_d = (a_above == b_above) ? prot_pkg::ST_NEXT
				: prot_pkg::ST_CROSS_CMP;
			prot_pkg::ST_CROSS_CMP: if (pd_done) st_d = prot_pkg::ST_NEXT;
			prot_pkg::ST_NEXT: begin
				if (last_q && !closing_q && tally_q == prot_pkg::TALLY_MAX)
					st_d = prot_pkg::ST_EDGE_LD;
				else if (last_q) st_d = prot_pkg::ST_RESULT;
				else st_d = prot_pkg::ST_IDLE;
			end
			prot_pkg::ST_RESULT: if (result.ready) st_d = prot_pkg::ST_IDLE;
			default: st_d = prot_pkg::ST_IDLE;
		endcase
	end

	// outputs: launch a job only once side and orientation indexes have settled
	always_comb begin
		pd_ctl.start = 1'b0;
		unique case (st_q)
			prot_pkg::ST_LAUNCH: pd_ctl.start = 1'b1;
			prot_pkg::ST_CROSS:  pd_ctl.start = (a_above != b_above);
			default: pd_ctl.start = 1'b0;
		endcase
	end

	assign vertex.ready = (st_q == prot_pkg::ST_IDLE);
	assign result.valid = (st_q == prot_pkg::ST_RESULT);
	assign result.data  = {res_ov_q, res_few_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= prot_pkg::ST_IDLE;
			fx_q <= '0; fy_q <= '0; qx_q <= '0; qy_q <= '0;
			tally_q <= '0; hit_q <= 1'b0; par_q <= 1'b0;
			closing_q <= 1'b0; side_q <= '0; oi_q <= '0; cross_alt_q <= 1'b0;
			res_ov_q <= 1'b0; res_few_q <= 1'b0; last_q <= 1'b0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				prot_pkg::ST_IDLE: if (take) begin
					vx_q <= vertex.data[2*CW:CW+1];
					vy_q <= vertex.data[CW:1];
					last_q <= vertex.data[0];
					closing_q <= 1'b0;
				end
				prot_pkg::ST_VTX: begin
					// vertex test, edge set up prior -> current
					if (in_rect(vx_q, vy_q, cl_q, ct_q, cr_q, cb_q)) hit_q <= 1'b1;
					if (tally_q == 2'd0) begin
						fx_q <= vx_q;
						fy_q <= vy_q;
					end
					ax_q <= qx_q; ay_q <= qy_q; bx_q <= vx_q; by_q <= vy_q;
					if (tally_q != prot_pkg::TALLY_MAX) tally_q <= tally_q + 1'b1;
					qx_q <= vx_q; qy_q <= vy_q;
					if (tally_q == 2'd0 && last_q) begin
						res_ov_q <= 1'b0;
						res_few_q <= 1'b1;
					end
				end
				prot_pkg::ST_EDGE_LD: begin
					side_q <= '0;
					oi_q <= '0;
					if (in_rect(ax_q, ay_q, cl_q, ct_q, cr_q, cb_q) ||
							in_rect(bx_q, by_q, cl_q, ct_q, cr_q, cb_q))
						hit_q <= 1'b1;
				end
				prot_pkg::ST_ORIENT: if (pd_done) begin
					o_q[oi_q] <= pd_sgn;
					oi_q <= oi_q + 1'b1;
				end
				prot_pkg::ST_SIDE: begin
					if (seg_meet) hit_q <= 1'b1;
					side_q <= side_q + 1'b1;
				end
				prot_pkg::ST_CROSS: cross_alt_q <= !same_sgn;
				prot_pkg::ST_CROSS_CMP: if (pd_done) begin
					// same sign: cross if (k+1)*den <= numa*numb; else k*den < numa*numb
					if (cross_alt_q ? (pd_sgn == 2'b11) : (pd_sgn != 2'b01))
						par_q <= !par_q;
				end
				prot_pkg::ST_NEXT: begin
					if (last_q && !closing_q && tally_q == prot_pkg::TALLY_MAX) begin
						closing_q <= 1'b1;
						ax_q <= vx_q; ay_q <= vy_q; bx_q <= fx_q; by_q <= fy_q;
					end else if (last_q) begin
						res_few_q <= (tally_q != prot_pkg::TALLY_MAX);
						res_ov_q  <= (tally_q == prot_pkg::TALLY_MAX) && (hit_q || par_q);
					end
				end
				prot_pkg::ST_RESULT: if (result.ready) begin
					// drop the polygon once the result transaction completes
					fx_q <= '0; fy_q <= '0; qx_q <= '0; qy_q <= '0;
					tally_q <= '0; hit_q <= 1'b0; par_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	`PROT_ASSERT_IMPL(a_no_both, clk, arst_n, 1'b1, !(vertex.ready && result.valid))
	`PROT_ASSERT_IMPL(a_few_not_ov, clk, arst_n, result.valid, !(result.data[1] && result.data[0]))
	`PROT_ASSERT_NEXT(a_take_busy, clk, arst_n, take, !vertex.ready)
	`PROT_ASSERT_NEXT(a_res_clear, clk, arst_n, result.valid && result.ready, tally_q == 2'd0)
endmodule
